// ===== design/skvt_pkg.sv =====
// skvt_pkg: shared types and constants of the string key/value table.
// Used by skvt_cell, skvt_ctrl and string_key_value_table.
package skvt_pkg;

  // Table geometry
  localparam int ENTRIES   = 64;
  localparam int KEY_BYTES = 25;
  localparam int KEY_W     = KEY_BYTES * 8;
  localparam int RAW_KEY_W = 200;
  localparam int VALUE_W   = 32;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int COUNT_OUT_W = 7;

  // Request codes
  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                      active;
    logic                      hit;
    logic                      free;
    logic signed [VALUE_W-1:0] value;
  } tok_t;

  // Write command broadcast to all cells after a scan
  typedef struct packed {
    logic                      update;
    logic                      remove;
    logic                      insert;
    logic signed [VALUE_W-1:0] value;
  } wr_t;

endpackage

// ===== design/skvt_cell.sv =====
// skvt_cell: one table entry (key, value, valid mark) plus its search stage.
// Depends on skvt_pkg.
module skvt_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [skvt_pkg::KEY_W-1:0]  key_i,
  input  skvt_pkg::wr_t               wr_i,
  input  skvt_pkg::tok_t              tok_i,
  output skvt_pkg::tok_t              tok_o,
  output logic                        valid_o,
  output logic                        match_o
);
  import skvt_pkg::*;

  logic [KEY_W-1:0]          key_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      valid_q;
  logic                      match_q;
  logic                      sel_q;
  tok_t                      tok_q;
  tok_t                      tok_d;
  logic                      match;

  assign match = valid_q && (key_q == key_i);

  // Fold this entry into the passing token
  always_comb begin
    tok_d        = tok_i;
    tok_d.hit    = tok_i.hit | match;
    tok_d.free   = tok_i.free | !valid_q;
    tok_d.value  = match ? value_q : tok_i.value;
  end

  // Token stage and per-entry flags from the last scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      match_q <= 1'b0;
      sel_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.active) begin
        match_q <= match;
        // lowest free slot: first invalid entry the token meets
        sel_q   <= !valid_q && !tok_i.free;
      end
      if (wr_i.remove && match_q) begin
        valid_q <= 1'b0;
      end else if (wr_i.insert && sel_q) begin
        valid_q <= 1'b1;
      end
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.insert && sel_q) begin
      key_q   <= key_i;
      value_q <= wr_i.value;
    end else if (wr_i.update && match_q) begin
      value_q <= wr_i.value;
    end
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

// ===== design/skvt_ctrl.sv =====
// skvt_ctrl: request capture, key trimming, scan sequencing and result logic.
// Depends on skvt_pkg.
module skvt_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type_i,
  input  logic [skvt_pkg::RAW_KEY_W-1:0]      raw_key_i,
  input  logic signed [skvt_pkg::VALUE_W-1:0] new_value_i,
  output logic [skvt_pkg::KEY_W-1:0]          key_o,
  output skvt_pkg::tok_t                      tok_o,
  input  skvt_pkg::tok_t                      tok_i,
  output skvt_pkg::wr_t                       wr_o,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic signed [skvt_pkg::VALUE_W-1:0] value_o,
  output logic [skvt_pkg::CNT_W-1:0]          count_o
);
  import skvt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_e;

  state_e                    state_q;
  logic                      launch_q;
  logic [1:0]                req_q;
  logic [KEY_W-1:0]          key_q;
  logic [KEY_W-1:0]          key_d;
  logic signed [VALUE_W-1:0] nval_q;
  logic [CNT_W-1:0]          count_q;
  wr_t                       wr_q;
  logic                      done_q;
  logic [1:0]                status_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      ended;
  logic [7:0]                kbyte;
  logic                      accept;

  assign accept = start && (state_q == S_IDLE);

  // Key ends at its first zero byte; clear everything after it
  always_comb begin
    ended = 1'b0;
    key_d = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      kbyte = raw_key_i[i*8 +: 8];
      if (ended) begin
        kbyte = 8'd0;
      end else if (kbyte == 8'd0) begin
        ended = 1'b1;
      end
      key_d[i*8 +: 8] = kbyte;
    end
  end

  // Request capture, scan sequencing, write command and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      req_q    <= REQ_PUT;
      count_q  <= '0;
      wr_q     <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      value_q  <= '0;
    end else begin
      launch_q <= 1'b0;
      wr_q     <= '0;
      done_q   <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q    <= req_type_i;
            launch_q <= 1'b1;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_i.active) begin
            done_q     <= 1'b1;
            status_q   <= ST_OK;
            value_q    <= '0;
            wr_q.value <= nval_q;
            state_q    <= S_WRITE;
            case (req_q)
              REQ_PUT: begin
                if (tok_i.hit) begin
                  wr_q.update <= 1'b1;
                end else if (tok_i.free) begin
                  wr_q.insert <= 1'b1;
                  count_q     <= count_q + CNT_W'(1);
                end else begin
                  status_q <= ST_FULL;
                end
              end
              REQ_GET: begin
                if (tok_i.hit) begin
                  value_q <= tok_i.value;
                end else begin
                  status_q <= ST_MISSING;
                end
              end
              REQ_REMOVE: begin
                if (tok_i.hit) begin
                  wr_q.remove <= 1'b1;
                  if (count_q != '0) begin
                    count_q <= count_q - CNT_W'(1);
                  end
                end else begin
                  status_q <= ST_MISSING;
                end
              end
              default: begin
                // unused code: no state change, plain ok result
              end
            endcase
          end
        end
        S_WRITE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= key_d;
      nval_q <= new_value_i;
    end
  end

  // Fresh token into the first cell
  always_comb begin
    tok_o        = '0;
    tok_o.active = launch_q;
  end

  assign busy     = (state_q != S_IDLE);
  assign key_o    = key_q;
  assign wr_o     = wr_q;
  assign done_o   = done_q;
  assign status_o = status_q;
  assign value_o  = value_q;
  assign count_o  = count_q;

endmodule

// ===== design/string_key_value_table.sv =====
// string_key_value_table: top level, controller plus a chain of ENTRIES cells.
// Depends on skvt_pkg, skvt_ctrl and skvt_cell.
// The search token walks the cell chain one cell per cycle, the controller registers
// the result and raises the result strobe, a write-back state keeps busy high, and
// the next request is taken only once the controller is idle again.
// Reset: asynchronous, active low; clears all valid marks and the entry count.
// Results are presented for one cycle on done_o; the receiver cannot stall.
module string_key_value_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [63:0]        key_bytes_0_7_i,
  input  logic [63:0]        key_bytes_8_15_i,
  input  logic [63:0]        key_bytes_16_23_i,
  input  logic [7:0]         key_byte_24_i,
  input  logic signed [31:0] new_value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] value_out_o,
  output logic [6:0]         entry_count_o
);
  import skvt_pkg::*;

  logic [RAW_KEY_W-1:0] raw_key;
  logic [KEY_W-1:0]     key;
  tok_t                 chain [ENTRIES+1];
  wr_t                  wr;
  logic [ENTRIES-1:0]   valid_vec;
  logic [ENTRIES-1:0]   match_vec;
  logic [CNT_W-1:0]     count;

  assign raw_key = {key_byte_24_i, key_bytes_16_23_i, key_bytes_8_15_i, key_bytes_0_7_i};

  skvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .raw_key_i   (raw_key),
    .new_value_i (new_value_i),
    .key_o       (key),
    .tok_o       (chain[0]),
    .tok_i       (chain[ENTRIES]),
    .wr_o        (wr),
    .done_o      (done_o),
    .status_o    (status_o),
    .value_o     (value_out_o),
    .count_o     (count)
  );

  // Row of entry cells, the search token moves one cell per cycle
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    skvt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key),
      .wr_i    (wr),
      .tok_i   (chain[g]),
      .tok_o   (chain[g+1]),
      .valid_o (valid_vec[g]),
      .match_o (match_vec[g])
    );
  end

  assign entry_count_o = COUNT_OUT_W'(count);

`ifndef SYNTHESIS
  // Live keys are unique, so a finished scan never flags two entries
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0(match_vec))
    else $error("more than one entry matched the key");

  // Entry count tracks the valid marks whenever the table is at rest
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> ($countones(valid_vec) == int'(count)))
    else $error("entry count disagrees with valid marks");

  // The result cycle is the write-back cycle, still busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a request");

  // Only one token in flight at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[0].active |-> !chain[ENTRIES].active)
    else $error("new token launched while another leaves the chain");

  // A result strobe lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");
`endif

endmodule
